### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on clk, off while reset is low.
`define PTSA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression that must never be true.
`define PTSA_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

### design/ptsa_pkg.sv
// ----------------------------------------------------------------------------
// ptsa_pkg
// Types and constants of the transpose scatter-accumulate block.
// ----------------------------------------------------------------------------
package ptsa_pkg;

  // width of bound and index arithmetic (trash * nonzeros fits in 18 bits)
  localparam int unsigned CALC_W  = 18;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [4:0]  NZR_RST = 5'd1;
  localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SUM_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ACCUM = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SKIP  = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_SAT   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_NZR     = 2'd0,
    REG_TRASH   = 2'd1,
    REG_IGNORE  = 2'd2,
    REG_ENTRIES = 2'd3
  } reg_e;

  typedef struct packed {
    logic [4:0]  nonzeros_per_row;
    logic [12:0] trash_pixel_count;
    logic        ignore_extra;
    logic [12:0] map_entries;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic sweep_wr;
    logic sweep_init;
    logic exec;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       sweep_done;
  } sts_t;

endpackage

### design/ptsa_cfg_regs.sv
// ----------------------------------------------------------------------------
// ptsa_cfg_regs
// APB register file holding the four configuration registers.
// ----------------------------------------------------------------------------
module ptsa_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptsa_pkg::PADDR_W-1:0]  paddr,
  input  logic [ptsa_pkg::PDATA_W-1:0]  pwdata,
  output logic [ptsa_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output ptsa_pkg::cfg_t                cfg_o
);

  ptsa_pkg::reg_e reg_sel;
  logic           wr_en;
  logic [4:0]     nzr_q;
  logic [12:0]    trash_q;
  logic           ignore_q;
  logic [12:0]    entries_q;

  assign reg_sel = ptsa_pkg::reg_e'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nzr_q     <= ptsa_pkg::NZR_RST;
      trash_q   <= '0;
      ignore_q  <= 1'b0;
      entries_q <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        ptsa_pkg::REG_NZR:     nzr_q     <= pwdata[4:0];
        ptsa_pkg::REG_TRASH:   trash_q   <= pwdata[12:0];
        ptsa_pkg::REG_IGNORE:  ignore_q  <= pwdata[0];
        ptsa_pkg::REG_ENTRIES: entries_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ptsa_pkg::REG_NZR:     prdata = ptsa_pkg::PDATA_W'(nzr_q);
      ptsa_pkg::REG_TRASH:   prdata = ptsa_pkg::PDATA_W'(trash_q);
      ptsa_pkg::REG_IGNORE:  prdata = ptsa_pkg::PDATA_W'(ignore_q);
      ptsa_pkg::REG_ENTRIES: prdata = ptsa_pkg::PDATA_W'(entries_q);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o.nonzeros_per_row  = nzr_q;
  assign cfg_o.trash_pixel_count = trash_q;
  assign cfg_o.ignore_extra      = ignore_q;
  assign cfg_o.map_entries       = entries_q;

endmodule

### design/ptsa_ctrl.sv
// ----------------------------------------------------------------------------
// ptsa_ctrl
// Sequencer: init sweep, item decode, clear sweep, execute, result handoff.
// ----------------------------------------------------------------------------
module ptsa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  ptsa_pkg::sts_t sts_i,
  output ptsa_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DECODE = 6'b000100,
    S_CLEAR  = 6'b001000,
    S_EXEC   = 6'b010000,
    S_RESP   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.sweep_init = 1'b1;
        cmd_o.sweep_wr   = !sts_i.sweep_done;
        if (sts_i.sweep_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        if (sts_i.func == ptsa_pkg::FUNC_CLEAR) state_d = S_CLEAR;
        else                                    state_d = S_EXEC;
      end
      S_CLEAR: begin
        cmd_o.sweep_wr = !sts_i.sweep_done;
        if (sts_i.sweep_done) state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        cmd_o.load_out = slot_free;
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### design/ptsa_datapath.sv
// ----------------------------------------------------------------------------
// ptsa_datapath
// Item registers, bound logic, map memory, multiplier and saturating adder.
// ----------------------------------------------------------------------------
module ptsa_datapath #(
  parameter int unsigned MAP_DEPTH = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptsa_pkg::cfg_t     cfg_i,
  input  ptsa_pkg::cmd_t     cmd_i,
  output ptsa_pkg::sts_t     sts_o,
  input  logic [1:0]         func_i,
  input  logic [11:0]        column_index_i,
  input  logic signed [15:0] weight_i,
  input  logic signed [31:0] sample_i,
  input  logic               first_of_row_i,
  output logic signed [63:0] map_value_o,
  output logic [1:0]         status_o
);

  localparam int unsigned AW = $clog2(MAP_DEPTH);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned CW = ptsa_pkg::CALC_W;

  // captured item
  logic [1:0]         func_q;
  logic [11:0]        col_q;
  logic signed [15:0] weight_q;
  logic signed [31:0] sample_q;
  logic               first_q;

  // bounds
  logic [CW-1:0] extra, off, ent_ext, avail, live_ext, col_ext, idx_ext;
  logic          acc_in_range, rd_in_range, skip_now;
  ptsa_pkg::status_e pre_status;

  // decode results
  logic                row_skipped_q;
  logic signed [47:0]  prod_q;
  logic [AW-1:0]       idx_q;
  logic                wr_ok_q, rd_ok_q;
  ptsa_pkg::status_e   pre_status_q;

  // sweep
  logic [SW-1:0] sweep_q, sweep_end;
  logic [CW-1:0] sweep_ext;

  // memory
  logic [63:0]   map_store_q [MAP_DEPTH];
  logic [63:0]   rd_data_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [63:0]   wr_data;
  logic          wr_en;

  // execute
  logic [64:0]       sum;
  logic              ovf;
  logic [63:0]       sat_sum;
  logic [63:0]       res_value_q, out_value_q;
  ptsa_pkg::status_e res_status_q, out_status_q;

  assign extra    = CW'(cfg_i.trash_pixel_count) * CW'(cfg_i.nonzeros_per_row);
  assign off      = cfg_i.ignore_extra ? extra : '0;
  assign ent_ext  = CW'(cfg_i.map_entries);
  assign avail    = (ent_ext > off) ? (ent_ext - off) : '0;
  assign live_ext = (avail > CW'(MAP_DEPTH)) ? CW'(MAP_DEPTH) : avail;
  assign col_ext  = CW'(col_q);
  assign idx_ext  = col_ext - off;

  assign acc_in_range = (col_ext >= off) && (idx_ext < live_ext);
  assign rd_in_range  = col_ext < live_ext;
  assign skip_now     = first_q ? (cfg_i.ignore_extra && (col_ext < extra)) : row_skipped_q;

  always_comb begin
    case (func_q)
      ptsa_pkg::FUNC_ACCUM: begin
        if (skip_now)           pre_status = ptsa_pkg::STATUS_SKIP;
        else if (!acc_in_range) pre_status = ptsa_pkg::STATUS_RANGE;
        else                    pre_status = ptsa_pkg::STATUS_OK;
      end
      ptsa_pkg::FUNC_READ: begin
        pre_status = rd_in_range ? ptsa_pkg::STATUS_OK : ptsa_pkg::STATUS_RANGE;
      end
      default: pre_status = ptsa_pkg::STATUS_OK;
    endcase
  end

  assign sweep_end = cmd_i.sweep_init ? SW'(MAP_DEPTH) : live_ext[SW-1:0];
  assign sweep_ext = CW'(sweep_q);

  assign sts_o.func       = func_q;
  assign sts_o.sweep_done = (sweep_q == sweep_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q       <= '0;
      row_skipped_q <= 1'b0;
    end else begin
      if (cmd_i.decode)        sweep_q <= '0;
      else if (cmd_i.sweep_wr) sweep_q <= sweep_q + SW'(1);
      if (cmd_i.decode && (func_q == ptsa_pkg::FUNC_ACCUM)) row_skipped_q <= skip_now;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= func_i;
      col_q    <= column_index_i;
      weight_q <= weight_i;
      sample_q <= sample_i;
      first_q  <= first_of_row_i;
    end
    if (cmd_i.decode) begin
      prod_q       <= weight_q * sample_q;
      idx_q        <= idx_ext[AW-1:0];
      wr_ok_q      <= (func_q == ptsa_pkg::FUNC_ACCUM) && !skip_now && acc_in_range;
      rd_ok_q      <= (func_q == ptsa_pkg::FUNC_READ) && rd_in_range;
      pre_status_q <= pre_status;
    end
    if (cmd_i.exec) begin
      res_value_q  <= rd_ok_q ? rd_data_q : '0;
      res_status_q <= (wr_ok_q && ovf) ? ptsa_pkg::STATUS_SAT : pre_status_q;
    end
    if (cmd_i.load_out) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
    end
  end

  assign rd_addr = (func_q == ptsa_pkg::FUNC_READ) ? col_ext[AW-1:0] : idx_ext[AW-1:0];

  assign sum     = {rd_data_q[63], rd_data_q} + {{17{prod_q[47]}}, prod_q};
  assign ovf     = sum[64] ^ sum[63];
  assign sat_sum = ovf ? (sum[64] ? ptsa_pkg::SUM_MIN : ptsa_pkg::SUM_MAX) : sum[63:0];

  assign wr_en   = cmd_i.sweep_wr || (cmd_i.exec && wr_ok_q);
  assign wr_addr = cmd_i.sweep_wr ? sweep_ext[AW-1:0] : idx_q;
  assign wr_data = cmd_i.sweep_wr ? '0 : sat_sum;

  always_ff @(posedge clk_i) begin
    if (wr_en)        map_store_q[wr_addr] <= wr_data;
    if (cmd_i.decode) rd_data_q <= map_store_q[rd_addr];
  end

  assign map_value_o = out_value_q;
  assign status_o    = out_status_q;

endmodule

### design/pointing_transpose_scatter_accumulate.sv
// ----------------------------------------------------------------------------
// pointing_transpose_scatter_accumulate
// Scatter-accumulate of x = A^t y into a saturating 64-bit map store.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | input     | in_valid_i/in_ready_o | func, column_index, weight,
//          |           |                       | sample, first_of_row
//  out     | output    | out_valid_o/out_ready_i | map_value, status
//  cfg     | input     | APB, pready tied high | four registers at 4*i
//
//  Accumulate, read and idle codes pass through capture, decode with memory
//  read and multiply, add-and-write, result handoff.
//  A clear zeroes one map entry per cycle over the live entries.
//  After reset the map is swept to zero; no item is
//  accepted then, config writes still are.
//  A new item is taken while the previous result waits on out_ready_i.
// ----------------------------------------------------------------------------
module pointing_transpose_scatter_accumulate #(
  parameter int unsigned MAP_DEPTH = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   func_i,
  input  logic [11:0]                  column_index_i,
  input  logic signed [15:0]           weight_i,
  input  logic signed [31:0]           sample_i,
  input  logic                         first_of_row_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [63:0]           map_value_o,
  output logic [1:0]                   status_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ptsa_pkg::PADDR_W-1:0] paddr,
  input  logic [ptsa_pkg::PDATA_W-1:0] pwdata,
  output logic [ptsa_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  ptsa_pkg::cfg_t cfg;
  ptsa_pkg::cmd_t cmd;
  ptsa_pkg::sts_t sts;

  ptsa_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ptsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ptsa_datapath #(
    .MAP_DEPTH (MAP_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .func_i         (func_i),
    .column_index_i (column_index_i),
    .weight_i       (weight_i),
    .sample_i       (sample_i),
    .first_of_row_i (first_of_row_i),
    .map_value_o    (map_value_o),
    .status_o       (status_o)
  );

endmodule

### design/ptsa_checker.sv
// ----------------------------------------------------------------------------
// ptsa_checker
// Port-level checks on item flow and result encoding, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptsa_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [63:0] map_value_o,
  input logic [1:0]         status_o
);

  `PTSA_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(map_value_o) && $stable(status_o), "result changed while stalled")

  `PTSA_ASSERT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "item taken while previous one in flight")

  `PTSA_ASSERT(a_no_fast_result, clk_i, rst_ni, in_valid_i && in_ready_o |=> !$rose(out_valid_o), "result one cycle after accept")

  `PTSA_ASSERT_NEVER(a_value_on_error, clk_i, rst_ni, out_valid_o && (status_o != ptsa_pkg::STATUS_OK) && (map_value_o != 64'sd0), "nonzero value with non-ok status")

endmodule

bind pointing_transpose_scatter_accumulate ptsa_checker u_ptsa_checker (.*);
